// ----- sv/qtp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qtp_pkg
// Shared types and constants of the quadtree path decoder and painter.
// ----------------------------------------------------------------------------
package qtp_pkg;

  localparam int KIND_W      = 2;
  localparam int CODE_W      = 14;
  localparam int QUOT_W      = 12;
  localparam int DIGIT_W     = 3;
  localparam int SIDE_W      = 7;
  localparam int SIDE_LOG2_W = 3;
  localparam int ROW_INDEX_W = 6;
  localparam int ROW_BITS_W  = 64;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 3;

  // input kinds
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PAINT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  // base-5 path digits
  localparam logic [DIGIT_W-1:0] DIG_END = 3'd0;
  localparam logic [DIGIT_W-1:0] DIG_UL  = 3'd1;
  localparam logic [DIGIT_W-1:0] DIG_UR  = 3'd2;
  localparam logic [DIGIT_W-1:0] DIG_LL  = 3'd3;
  localparam logic [DIGIT_W-1:0] DIG_LR  = 3'd4;

  // register index, taken from the word address bit
  localparam logic REG_SIDE_LOG2 = 1'b0;

  localparam logic [SIDE_LOG2_W-1:0] SIDE_LOG2_MAX   = 3'd6;
  localparam logic [SIDE_LOG2_W-1:0] SIDE_LOG2_RESET = 3'd6;

  // t / 5 = (t * 13108) >> 16, exact for any 14-bit t
  localparam logic [CODE_W-1:0] DIV5_RECIP = 14'd13108;
  localparam int                DIV5_SHIFT = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PAINT,
    ST_READ
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } store_ctl_t;

  // contiguous run of width ones starting at bit start
  function automatic logic [ROW_BITS_W-1:0] span_mask(input logic [SIDE_W-1:0] width,
                                                      input logic [SIDE_W-1:0] start);
    logic [ROW_BITS_W-1:0] m;
    if (width >= SIDE_W'(ROW_BITS_W)) begin
      m = '1;
    end else begin
      m = (ROW_BITS_W'(1) << width) - ROW_BITS_W'(1);
    end
    if (start >= SIDE_W'(ROW_BITS_W)) begin
      return '0;
    end
    return m << start;
  endfunction

endpackage
`default_nettype wire

// ----- sv/qtp_div5.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qtp_div5
// Digit unit: splits a 14-bit code into its lowest base-5 digit and the rest.
// ----------------------------------------------------------------------------
module qtp_div5
  import qtp_pkg::*;
(
  input  wire logic [CODE_W-1:0]  code_in,
  output logic      [QUOT_W-1:0]  quot,
  output logic      [DIGIT_W-1:0] digit
);

  logic [2*CODE_W-1:0] prod;
  logic [CODE_W-1:0]   times5;
  logic [CODE_W-1:0]   rem;

  always_comb begin
    prod   = (2*CODE_W)'(code_in) * (2*CODE_W)'(DIV5_RECIP);
    quot   = prod[DIV5_SHIFT +: QUOT_W];
    times5 = (CODE_W'(quot) << 2) + CODE_W'(quot);
    rem    = code_in - times5;
    digit  = rem[DIGIT_W-1:0];
  end

endmodule
`default_nettype wire

// ----- sv/qtp_store.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qtp_store
// Bitmap row memory with per-row valid bits; an unwritten row reads as zero.
// ----------------------------------------------------------------------------
module qtp_store
  import qtp_pkg::*;
#(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6,
  parameter int DATA_W = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire store_ctl_t        ctl,
  input  wire logic [ADDR_W-1:0] rd_addr,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  row_vld;
  logic [DATA_W-1:0] rd_q;
  logic              rd_q_vld;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // clear drops every valid bit at once
  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      row_vld <= '0;
    end else if (ctl.wr_en) begin
      row_vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_q_vld <= row_vld[rd_addr];
    end
  end

  assign rd_data = rd_q_vld ? rd_q : '0;

endmodule
`default_nettype wire

// ----- sv/quadtree_path_decode_paint.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quadtree_path_decode_paint
// Paints base-5 linear quadtree paths into a square bitmap and reads it out.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries kind and node_code. kind 0 clears
// the bitmap, kind 1 paints the square named by node_code, kind 2 reads the
// image out, kind 3 is dropped. Only a readout produces results on the
// output channel (out_valid/out_ready): one transaction per row, row 0
// first, last set on the final row. The image side is 2^side_log2, capped at
// 6 and at MAX_SIDE, written through the APB port at address 0.
// Paint: the code digits, the ending zero digit included, are taken in turn
// from the single divide-by-5 unit, then the painted rows go through a
// read-modify-write of the row memory. Readout: one row per cycle through
// the single memory read port while the receiver keeps out_ready high. The
// input is not ready while a paint or readout is in progress; a finished row
// waits in the output register, and a stalled receiver holds the row walk.
// Reset sets side_log2 to 6, empties the bitmap by dropping all row valid
// bits, and leaves the block idle with no result pending.
// ----------------------------------------------------------------------------
module quadtree_path_decode_paint
  import qtp_pkg::*;
#(
  parameter int MAX_SIDE = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [KIND_W-1:0]      kind,
  input  wire logic [CODE_W-1:0]      node_code,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic      [ROW_INDEX_W-1:0] row_index,
  output logic      [ROW_BITS_W-1:0]  row_bits,
  output logic                        last,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [CFG_ADDR_W-1:0]  paddr,
  input  wire logic [CFG_DATA_W-1:0]  pwdata,
  output logic      [CFG_DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam int ROW_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam logic [SIDE_W-1:0] MAX_SIDE_C = SIDE_W'(MAX_SIDE);

  // configuration
  logic [SIDE_LOG2_W-1:0] side_log2;
  logic [SIDE_LOG2_W-1:0] lg_clip;
  logic [SIDE_W-1:0]      side_pow;
  logic [SIDE_W-1:0]      side;
  logic [ROW_BITS_W-1:0]  col_mask;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SIDE_LOG2) ? CFG_DATA_W'(side_log2) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      side_log2 <= SIDE_LOG2_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_SIDE_LOG2) begin
      side_log2 <= pwdata[SIDE_LOG2_W-1:0];
    end
  end

  always_comb begin
    lg_clip  = (side_log2 > SIDE_LOG2_MAX) ? SIDE_LOG2_MAX : side_log2;
    side_pow = SIDE_W'(1) << lg_clip;
    side     = (side_pow > MAX_SIDE_C) ? MAX_SIDE_C : side_pow;
    col_mask = span_mask(side, '0);
  end

  // sequencer and datapath registers
  state_t                state, state_next;
  logic [CODE_W-1:0]     code, code_next;
  logic [SIDE_W-1:0]     width, width_next;
  logic [SIDE_W-1:0]     top, top_next;
  logic [SIDE_W-1:0]     left, left_next;
  logic [SIDE_W-1:0]     row_ptr, row_ptr_next;
  logic [SIDE_W-1:0]     row_end, row_end_next;
  logic [SIDE_W-1:0]     row_tag, row_tag_next;
  logic                  rd_valid, rd_valid_next;
  logic [MAX_SIDE-1:0]   paint_mask, paint_mask_next;
  logic                  out_valid_next;
  logic [ROW_INDEX_W-1:0] row_index_next;
  logic [ROW_BITS_W-1:0] row_bits_next;
  logic                  last_next;

  logic [QUOT_W-1:0]     quot;
  logic [DIGIT_W-1:0]    digit;
  logic [SIDE_W-1:0]     width_half;
  logic [ROW_BITS_W-1:0] span;
  logic                  rd_issue;
  logic                  load_out;

  store_ctl_t            st_ctl;
  logic [MAX_SIDE-1:0]   st_rd_data;
  logic [MAX_SIDE-1:0]   st_wr_data;

  qtp_div5 u_div5 (
    .code_in (code),
    .quot    (quot),
    .digit   (digit)
  );

  qtp_store #(
    .DEPTH  (MAX_SIDE),
    .ADDR_W (ROW_W),
    .DATA_W (MAX_SIDE)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .ctl     (st_ctl),
    .rd_addr (row_ptr[ROW_W-1:0]),
    .wr_addr (row_tag[ROW_W-1:0]),
    .wr_data (st_wr_data),
    .rd_data (st_rd_data)
  );

  assign st_wr_data = st_rd_data | paint_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rd_valid  <= rd_valid_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    code       <= code_next;
    width      <= width_next;
    top        <= top_next;
    left       <= left_next;
    row_ptr    <= row_ptr_next;
    row_end    <= row_end_next;
    row_tag    <= row_tag_next;
    paint_mask <= paint_mask_next;
    row_index  <= row_index_next;
    row_bits   <= row_bits_next;
    last       <= last_next;
  end

  always_comb begin
    state_next      = state;
    code_next       = code;
    width_next      = width;
    top_next        = top;
    left_next       = left;
    row_ptr_next    = row_ptr;
    row_end_next    = row_end;
    row_tag_next    = row_tag;
    rd_valid_next   = rd_valid;
    paint_mask_next = paint_mask;
    row_index_next  = row_index;
    row_bits_next   = row_bits;
    last_next       = last;
    out_valid_next  = out_valid && !out_ready;
    st_ctl          = '0;
    in_ready        = 1'b0;
    width_half      = width >> 1;
    span            = span_mask(width, left);
    rd_issue        = 1'b0;
    load_out        = 1'b0;

    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (kind)
            KIND_CLEAR: begin
              st_ctl.clr = 1'b1;
            end
            KIND_PAINT: begin
              code_next  = node_code;
              width_next = side;
              top_next   = '0;
              left_next  = '0;
              state_next = ST_DECODE;
            end
            KIND_READ: begin
              row_ptr_next  = '0;
              row_end_next  = side;
              rd_valid_next = 1'b0;
              state_next    = ST_READ;
            end
            default: begin
            end
          endcase
        end
      end

      // one base-5 digit per cycle
      ST_DECODE: begin
        if (digit == DIG_END) begin
          if (width == '0) begin
            state_next = ST_IDLE;
          end else begin
            row_ptr_next    = top;
            row_end_next    = top + width;
            paint_mask_next = span[MAX_SIDE-1:0];
            rd_valid_next   = 1'b0;
            state_next      = ST_PAINT;
          end
        end else begin
          width_next = width_half;
          if (digit inside {DIG_UR, DIG_LR}) begin
            left_next = left + width_half;
          end
          if (digit inside {DIG_LL, DIG_LR}) begin
            top_next = top + width_half;
          end
          code_next = CODE_W'(quot);
        end
      end

      // read row, or it in, write back in the next cycle
      ST_PAINT: begin
        rd_issue      = row_ptr < row_end;
        st_ctl.rd_en  = rd_issue;
        st_ctl.wr_en  = rd_valid;
        rd_valid_next = rd_issue;
        if (rd_issue) begin
          row_tag_next = row_ptr;
          row_ptr_next = row_ptr + SIDE_W'(1);
        end
        if (!rd_issue && !rd_valid) begin
          state_next = ST_IDLE;
        end
      end

      ST_READ: begin
        load_out     = rd_valid && (!out_valid || out_ready);
        rd_issue     = (row_ptr < row_end) && (!rd_valid || load_out);
        st_ctl.rd_en = rd_issue;
        if (load_out) begin
          out_valid_next = 1'b1;
          row_index_next = row_tag[ROW_INDEX_W-1:0];
          row_bits_next  = ROW_BITS_W'(st_rd_data) & col_mask;
          last_next      = (row_tag + SIDE_W'(1)) == side;
        end
        if (rd_issue) begin
          row_tag_next  = row_ptr;
          row_ptr_next  = row_ptr + SIDE_W'(1);
          rd_valid_next = 1'b1;
        end else if (load_out) begin
          rd_valid_next = 1'b0;
        end
        if (row_ptr == row_end && (!rd_valid || load_out)) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- dv/quadtree_path_decode_paint_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadtree_path_decode_paint_test
// Self-checking bench for the base-5 quadtree painter. Clear, paint and
// readout transactions go in through a queue-fed driver. An in-bench bitmap
// model predicts every readout row, and a monitor checks rows in order. The
// image side is stepped through several settings over the APB port while idle.
// ----------------------------------------------------------------------------
module quadtree_path_decode_paint_test;
  import qtp_pkg::*;

  localparam logic [KIND_W-1:0]     KIND_UNUSED    = 2'd3;
  localparam logic [CFG_ADDR_W-1:0] SIDE_LOG2_ADDR = '0;
  localparam int unsigned           CODE_BASE      = 5;
  localparam int unsigned           STORE_ROWS     = 64;
  localparam int                    SETTLE_CYCLES  = 100;
  localparam int                    HOLD_CYCLES    = 400;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [CODE_W-1:0] code;
  } item_t;

  typedef struct {
    logic [ROW_INDEX_W-1:0] row_index;
    logic [ROW_BITS_W-1:0]  row_bits;
    logic                   last;
  } row_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  logic [KIND_W-1:0]      kind      = '0;
  logic [CODE_W-1:0]      node_code = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [ROW_INDEX_W-1:0] row_index;
  logic [ROW_BITS_W-1:0]  row_bits;
  logic                   last;
  logic                   psel      = 1'b0;
  logic                   penable   = 1'b0;
  logic                   pwrite    = 1'b0;
  logic [CFG_ADDR_W-1:0]  paddr     = '0;
  logic [CFG_DATA_W-1:0]  pwdata    = '0;
  logic [CFG_DATA_W-1:0]  prdata;
  logic                   pready;

  item_t pending_items[$];
  row_t  rows_due[$];

  // bitmap model and its side setting
  logic [ROW_BITS_W-1:0]  img_rows[STORE_ROWS] = '{default: '0};
  logic [SIDE_LOG2_W-1:0] side_sel = SIDE_LOG2_RESET;

  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  int   mismatches  = 0;
  logic in_taken    = 1'b0;
  logic hold_kick   = 1'b0;
  logic hold_done   = 1'b0;
  int   hold_left   = 0;

  quadtree_path_decode_paint DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .node_code (node_code),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .row_index (row_index),
    .row_bits  (row_bits),
    .last      (last),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  function automatic int unsigned eff_log2();
    return (side_sel > SIDE_LOG2_MAX) ? SIDE_LOG2_MAX : side_sel;
  endfunction

  function automatic logic [ROW_BITS_W-1:0] ones(input int unsigned width);
    return (width >= ROW_BITS_W) ? '1 : ((ROW_BITS_W'(1) << width) - ROW_BITS_W'(1));
  endfunction

  // walk the base-5 path and blacken the square it lands on
  function automatic void paint_square(input logic [CODE_W-1:0] code);
    int unsigned t, w, r, c;
    logic [DIGIT_W-1:0] d;
    logic [ROW_BITS_W-1:0] m;
    t = code;
    w = 1 << eff_log2();
    r = 0;
    c = 0;
    while (DIGIT_W'(t % CODE_BASE) != DIG_END) begin
      d = DIGIT_W'(t % CODE_BASE);
      w = w / 2;
      if (d == DIG_UR || d == DIG_LR) c += w;
      if (d == DIG_LL || d == DIG_LR) r += w;
      t = t / CODE_BASE;
    end
    if (w != 0) begin
      m = ones(w) << c;
      for (int unsigned i = r; i < r + w && i < STORE_ROWS; i++) img_rows[i] |= m;
    end
  endfunction

  function automatic void queue_readout();
    int unsigned side;
    row_t e;
    side = 1 << eff_log2();
    for (int unsigned i = 0; i < side; i++) begin
      e.row_index = ROW_INDEX_W'(i);
      e.row_bits  = img_rows[i] & ones(side);
      e.last      = (i == side - 1);
      rows_due.insert(rows_due.size(), e);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // driver: next transaction goes out once the current one is taken
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_valid  <= 1'b1;
        kind      <= pending_items[0].kind;
        node_code <= pending_items[0].code;
        void'(pending_items.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_kick && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // monitor: predict on accepted input, check each row transaction
  always @(posedge clk) begin : monitor
    row_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (rows_due.size() == 0) begin
          report_mismatch($sformatf("row %0d arrived with none expected", row_index));
        end else begin
          want = rows_due.pop_front();
          if (row_index !== want.row_index)
            report_mismatch($sformatf("row_index %0d, expected %0d", row_index,
                                      want.row_index));
          if (row_bits !== want.row_bits)
            report_mismatch($sformatf("row %0d bits %h, expected %h", want.row_index,
                                      row_bits, want.row_bits));
          if (last !== want.last)
            report_mismatch($sformatf("row %0d last %b, expected %b", want.row_index,
                                      last, want.last));
        end
      end
      if (in_valid && in_ready) begin
        case (kind)
          KIND_CLEAR: img_rows = '{default: '0};
          KIND_PAINT: paint_square(node_code);
          KIND_READ:  queue_readout();
          default:    ;
        endcase
      end
    end
  end

  task automatic push(input logic [KIND_W-1:0] k, input logic [CODE_W-1:0] code);
    item_t it;
    it.kind = k;
    it.code = code;
    pending_items.insert(pending_items.size(), it);
  endtask

  // mostly well-formed paths, some one level too deep, plus raw codes, clears, reads and unused kinds
  task automatic push_random(input int n);
    int unsigned roll, depth, code, pw, max_depth;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      code = $urandom_range((1 << CODE_W) - 1);
      if (roll < 8) begin
        push(KIND_CLEAR, code);
      end else if (roll < 12) begin
        push(KIND_UNUSED, code);
      end else if (roll < 27) begin
        push(KIND_READ, code);
      end else if (roll < 37) begin
        push(KIND_PAINT, code);
      end else begin
        max_depth = (eff_log2() + 1 > 6) ? 6 : eff_log2() + 1;
        depth = $urandom_range(max_depth);
        code = 0;
        pw = 1;
        for (int unsigned k = 0; k < depth; k++) begin
          code += $urandom_range(DIG_LR, DIG_UL) * pw;
          pw *= CODE_BASE;
        end
        push(KIND_PAINT, CODE_W'(code));
      end
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || rows_due.size() != 0);
    // a trailing paint can still be busy with no result to wait for
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_side_log2(input logic [SIDE_LOG2_W-1:0] v);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = SIDE_LOG2_ADDR;
    pwdata  = ($urandom() & ~CFG_DATA_W'(7)) | CFG_DATA_W'(v);
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    side_sel = v;
  endtask

  initial begin
    tx_idle_pct = 10;
    rx_idle_pct = 76;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // full 64-pixel side after reset
    push(KIND_READ, '0);
    push(KIND_PAINT, 14'd0);      // empty path covers the image
    push(KIND_READ, '1);
    push(KIND_CLEAR, '0);
    push(KIND_PAINT, 14'd7);      // upper-right, then its upper-left
    push(KIND_PAINT, 14'd15624);  // lower-right at every level
    push(KIND_PAINT, '1);
    push(KIND_PAINT, 14'd3);      // lower-left quadrant
    push(KIND_UNUSED, '1);
    push(KIND_READ, '0);
    push(KIND_CLEAR, '1);
    push(KIND_PAINT, 14'd5);      // zero lowest digit stops the walk at once
    push(KIND_READ, '0);
    push(KIND_CLEAR, '0);
    push(KIND_PAINT, 14'd1);
    push(KIND_PAINT, 14'd4);
    push(KIND_READ, '0);
    wait_idle();

    // single pixel: any digit goes deeper than the image
    write_side_log2(3'd0);
    push(KIND_CLEAR, '0);
    push(KIND_PAINT, 14'd1);
    push(KIND_READ, '0);
    push(KIND_PAINT, 14'd0);
    push(KIND_READ, '0);
    wait_idle();

    write_side_log2(3'd3);
    push_random(20);
    wait_idle();

    // out-of-range side acts as 64; receiver backs off while reads pile up
    tx_idle_pct = 76;
    rx_idle_pct = 10;
    write_side_log2(3'd7);
    push(KIND_READ, '0);
    push(KIND_PAINT, 14'd2);
    push(KIND_READ, '0);
    push_random(20);
    hold_kick = 1'b1;
    wait_idle();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_side_log2(3'd1);
    push_random(20);
    wait_idle();

    write_side_log2(3'd6);
    push_random(25);
    wait_idle();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
